@@ design/sigmoid_neuron_forward_macros.svh @@
// assertion macros for the sigmoid neuron forward block
`ifndef SIGMOID_NEURON_FORWARD_MACROS_SVH
`define SIGMOID_NEURON_FORWARD_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SNF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SNF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SNF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define SNF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/snf_pkg.sv @@
// shared types and constants of the sigmoid neuron forward block
package snf_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned ACC_W      = 40;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned ACT_W      = 16;
  localparam int unsigned DER_W      = 15;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BIAS        = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_SIGMOID = 1'b1;

  // |z| in Q.32, reduction quotient, series and reciprocal widths
  localparam int unsigned X_W   = 36;
  localparam int unsigned K_W   = 5;
  localparam int unsigned R_W   = 32;
  localparam int unsigned SER_W = 34;
  localparam int unsigned D_W   = 34;
  localparam int unsigned Q_W   = 17;
  localparam int unsigned NR_W  = 4;

  localparam logic [R_W-1:0]   LN2_Q32   = 32'd2977044472;
  localparam logic [SUM_W-1:0] MAG_LIMIT = 32'd268435456;
  localparam logic [DER_W-1:0] DER_MAX   = 15'd16384;

  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] RED_FIRST  = 5'd4;
  localparam logic [STEP_W-1:0] TERM_FIRST = 5'd2;
  localparam logic [STEP_W-1:0] TERM_LAST  = 5'd13;
  localparam logic [STEP_W-1:0] RCP_LAST   = 5'(Q_W - 1);

  // term divider: quotient bits per cycle
  localparam int unsigned DIV_BITS = 4;
  localparam int unsigned DIV_CYC  = R_W / DIV_BITS;
  localparam int unsigned SUB_W    = $clog2(DIV_CYC);
  localparam logic [SUB_W-1:0] DIV_SUB_LAST = SUB_W'(DIV_CYC - 1);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_BIAS,
    OP_SETUP,
    OP_RED,
    OP_SINIT,
    OP_MUL,
    OP_DIV,
    OP_ACCUM,
    OP_RCP_D,
    OP_RCP_N,
    OP_RCP,
    OP_SIGN,
    OP_DER,
    OP_LOAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e              op;
    logic [STEP_W-1:0]   step;
  } dp_cmd_t;

  typedef struct packed {
    logic sigmoid;
    logic sat_mag;
  } dp_status_t;

endpackage

@@ design/snf_in_if.sv @@
// input word channel of the sigmoid neuron forward block
interface snf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [snf_pkg::DATA_W-1:0]   input_value;
  logic signed [snf_pkg::DATA_W-1:0]   weight_value;
  logic                                last;

  modport source (output valid, input_value, weight_value, last, input ready);
  modport sink (input valid, input_value, weight_value, last, output ready);
endinterface

@@ design/snf_out_if.sv @@
// result word channel of the sigmoid neuron forward block
interface snf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [snf_pkg::SUM_W-1:0]   weighted_sum;
  logic [snf_pkg::ACT_W-1:0]          activation;
  logic [snf_pkg::DER_W-1:0]          derivative;
  logic                               supported;

  modport source (output valid, weighted_sum, activation, derivative, supported,
                  input ready);
  modport sink (input valid, weighted_sum, activation, derivative, supported,
                output ready);
endinterface

@@ design/snf_ctrl.sv @@
// controller state machine of the sigmoid neuron forward block
module snf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  input  snf_pkg::dp_status_t  status_i,
  output snf_pkg::dp_cmd_t     cmd_o
);

  localparam logic [3:0] S_ACC   = 4'd0;
  localparam logic [3:0] S_ADD   = 4'd1;
  localparam logic [3:0] S_BIAS  = 4'd2;
  localparam logic [3:0] S_SETUP = 4'd3;
  localparam logic [3:0] S_RED   = 4'd4;
  localparam logic [3:0] S_SINIT = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_ACCUM = 4'd8;
  localparam logic [3:0] S_RCPD  = 4'd9;
  localparam logic [3:0] S_RCPN  = 4'd10;
  localparam logic [3:0] S_RCP   = 4'd11;
  localparam logic [3:0] S_SIGN  = 4'd12;
  localparam logic [3:0] S_DER   = 4'd13;
  localparam logic [3:0] S_LOAD  = 4'd14;

  logic [3:0]                   state_q, state_d;
  logic [snf_pkg::STEP_W-1:0]   cnt_q, cnt_d;
  logic [snf_pkg::SUB_W-1:0]    sub_q, sub_d;
  logic                         out_vld_q, out_vld_d;
  logic                         slot_free;

  assign in_ready_o  = (state_q == S_ACC);
  assign out_valid_o = out_vld_q;
  assign slot_free   = !out_vld_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    sub_d      = sub_q;
    cmd_o.op   = snf_pkg::OP_NONE;
    cmd_o.step = cnt_q;
    unique case (state_q)
      S_ACC: begin
        if (in_valid_i && in_last_i) state_d = S_ADD;
      end
      S_ADD: state_d = S_BIAS;
      S_BIAS: begin
        cmd_o.op = snf_pkg::OP_BIAS;
        state_d  = status_i.sigmoid ? S_SETUP : S_LOAD;
      end
      S_SETUP: begin
        cmd_o.op = snf_pkg::OP_SETUP;
        if (status_i.sat_mag) begin
          state_d = S_SIGN;
        end else begin
          state_d = S_RED;
          cnt_d   = snf_pkg::RED_FIRST;
        end
      end
      S_RED: begin
        cmd_o.op = snf_pkg::OP_RED;
        if (cnt_q == '0) state_d = S_SINIT;
        else cnt_d = cnt_q - 1'b1;
      end
      S_SINIT: begin
        cmd_o.op = snf_pkg::OP_SINIT;
        cnt_d    = snf_pkg::TERM_FIRST;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = snf_pkg::OP_MUL;
        sub_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = snf_pkg::OP_DIV;
        if (sub_q == snf_pkg::DIV_SUB_LAST) state_d = S_ACCUM;
        else sub_d = sub_q + 1'b1;
      end
      S_ACCUM: begin
        cmd_o.op = snf_pkg::OP_ACCUM;
        if (cnt_q == snf_pkg::TERM_LAST) begin
          state_d = S_RCPD;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_MUL;
        end
      end
      S_RCPD: begin
        cmd_o.op = snf_pkg::OP_RCP_D;
        state_d  = S_RCPN;
      end
      S_RCPN: begin
        cmd_o.op = snf_pkg::OP_RCP_N;
        cnt_d    = '0;
        state_d  = S_RCP;
      end
      S_RCP: begin
        cmd_o.op = snf_pkg::OP_RCP;
        if (cnt_q == snf_pkg::RCP_LAST) state_d = S_SIGN;
        else cnt_d = cnt_q + 1'b1;
      end
      S_SIGN: begin
        cmd_o.op = snf_pkg::OP_SIGN;
        state_d  = S_DER;
      end
      S_DER: begin
        cmd_o.op = snf_pkg::OP_DER;
        state_d  = S_LOAD;
      end
      S_LOAD: begin
        if (slot_free) begin
          cmd_o.op = snf_pkg::OP_LOAD;
          state_d  = S_ACC;
        end
      end
      default: state_d = S_ACC;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    priority if (state_q == S_LOAD && slot_free) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_ACC;
      cnt_q     <= '0;
      sub_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      sub_q     <= sub_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

@@ design/snf_datapath.sv @@
// accumulator, sigmoid evaluation datapath and result register
module snf_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [snf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [snf_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 in_accept_i,
  input  logic signed [snf_pkg::DATA_W-1:0]    input_value_i,
  input  logic signed [snf_pkg::DATA_W-1:0]    weight_value_i,
  input  snf_pkg::dp_cmd_t                     cmd_i,
  output snf_pkg::dp_status_t                  status_o,
  output logic signed [snf_pkg::SUM_W-1:0]     weighted_sum_o,
  output logic [snf_pkg::ACT_W-1:0]            activation_o,
  output logic [snf_pkg::DER_W-1:0]            derivative_o,
  output logic                                 supported_o
);

  localparam int unsigned AW  = snf_pkg::ACC_W;
  localparam int unsigned PW  = snf_pkg::PROD_W;
  localparam int unsigned ZW  = snf_pkg::SUM_W;
  localparam int unsigned XW  = snf_pkg::X_W;
  localparam int unsigned RW  = snf_pkg::R_W;
  localparam int unsigned SW  = snf_pkg::SER_W;
  localparam int unsigned DW  = snf_pkg::D_W;
  localparam int unsigned QW  = snf_pkg::Q_W;
  localparam int unsigned NW  = snf_pkg::NR_W;
  localparam int unsigned SHW = $clog2(snf_pkg::K_W);

  localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};
  localparam logic signed [ZW-1:0] Z_MAX   = {1'b0, {(ZW-1){1'b1}}};
  localparam logic signed [ZW-1:0] Z_MIN   = {1'b1, {(ZW-1){1'b0}}};
  localparam logic signed [SW-1:0] SER_ONE = SW'(64'd1 << RW);
  localparam logic [DW-1:0]        D_ONE   = DW'(64'd1 << RW);
  localparam logic [DW-1:0]        N_HIGH  = DW'(64'd1 << (2 * QW - 3));
  localparam logic [QW-1:0]        P_ONE   = QW'(32'd1 << (QW - 1));
  localparam logic [2*QW-1:0]      DER_RND = (2*QW)'(32'd1 << (QW - 2));

  // config registers
  logic signed [ZW-1:0]  bias_q;
  logic                  act_sig_q;

  // accumulate path
  logic signed [PW-1:0]  prod_q;
  logic                  prod_vld_q;
  logic signed [AW-1:0]  acc_q;
  logic signed [AW:0]    acc_sum;
  logic signed [AW-1:0]  acc_sat;
  logic signed [AW:0]    z_sum;
  logic signed [ZW-1:0]  z_sat;

  // sigmoid path
  logic signed [ZW-1:0]    z_q;
  logic [ZW-1:0]           mag;
  logic [XW-1:0]           x_q;
  logic [XW-1:0]           ln2_sh;
  logic [snf_pkg::K_W-1:0] k_q;
  logic [RW-1:0]           r_val;
  logic [RW-1:0]           term_q;
  logic [2*RW-1:0]         term_prod;
  logic signed [SW-1:0]    sum_q;
  logic [RW-1:0]           dvd_q;
  logic [NW-1:0]           nrem_q;
  logic [RW-1:0]           dvd_next;
  logic [NW-1:0]           nrem_next;
  logic [RW:0]             e_val;
  logic [DW-1:0]           d_q;
  logic [DW-1:0]           rr_q;
  logic [QW-1:0]           qn_q;
  logic [DW:0]             rcp_trial;
  logic [QW-1:0]           p_val;
  logic [QW-1:0]           s_q;
  logic [2*QW-1:0]         der_prod;
  logic [snf_pkg::DER_W-1:0] der_q;

  // result register
  logic signed [ZW-1:0]         out_sum_q;
  logic [snf_pkg::ACT_W-1:0]    out_act_q;
  logic [snf_pkg::DER_W-1:0]    out_der_q;
  logic                         out_sup_q;

  assign acc_sum = (AW+1)'(acc_q) + (AW+1)'(prod_q);
  always_comb begin
    acc_sat = acc_sum[AW-1:0];
    if (acc_sum[AW] != acc_sum[AW-1]) acc_sat = acc_sum[AW] ? ACC_MIN : ACC_MAX;
  end

  assign z_sum = (AW+1)'(acc_q) + (AW+1)'(bias_q);
  always_comb begin
    z_sat = z_sum[ZW-1:0];
    if (!((z_sum[AW:ZW-1] == '0) || (z_sum[AW:ZW-1] == '1))) begin
      z_sat = z_sum[AW] ? Z_MIN : Z_MAX;
    end
  end

  assign mag       = z_q[ZW-1] ? (~$unsigned(z_q) + 1'b1) : $unsigned(z_q);
  assign ln2_sh    = XW'(snf_pkg::LN2_Q32) << cmd_i.step[SHW-1:0];
  assign r_val     = x_q[RW-1:0];
  assign term_prod = term_q * r_val;
  assign e_val     = sum_q[RW:0] >> k_q;
  assign rcp_trial = {rr_q, qn_q[QW-1]};
  assign p_val     = status_o.sat_mag ? P_ONE : qn_q;
  assign der_prod  = (2*QW)'(s_q) * (2*QW)'(P_ONE - s_q) + DER_RND;

  assign status_o.sigmoid = act_sig_q;
  assign status_o.sat_mag = (mag >= snf_pkg::MAG_LIMIT);

  // restoring division of the series term by n, several quotient bits a cycle
  always_comb begin
    logic [NW:0]   trial;
    logic [NW-1:0] rem_t;
    logic [RW-1:0] dv_t;
    rem_t = nrem_q;
    dv_t  = dvd_q;
    for (int i = 0; i < int'(snf_pkg::DIV_BITS); i++) begin
      trial = {rem_t, dv_t[RW-1]};
      dv_t  = {dv_t[RW-2:0], 1'b0};
      if (trial >= cmd_i.step) begin
        trial   = trial - cmd_i.step;
        dv_t[0] = 1'b1;
      end
      rem_t = trial[NW-1:0];
    end
    dvd_next  = dv_t;
    nrem_next = rem_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q     <= '0;
      act_sig_q  <= 1'b1;
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          snf_pkg::CFG_BIAS:        bias_q    <= cfg_wdata_i;
          snf_pkg::CFG_ACT_SIGMOID: act_sig_q <= cfg_wdata_i[0];
        endcase
      end
      prod_vld_q <= in_accept_i;
      if (cmd_i.op == snf_pkg::OP_BIAS) acc_q <= '0;
      else if (prod_vld_q) acc_q <= acc_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) prod_q <= PW'(input_value_i) * PW'(weight_value_i);
    unique case (cmd_i.op)
      snf_pkg::OP_NONE: ;
      snf_pkg::OP_BIAS: z_q <= z_sat;
      snf_pkg::OP_SETUP: begin
        x_q <= XW'({mag, 8'b0});
        k_q <= '0;
      end
      snf_pkg::OP_RED: begin
        if (x_q >= ln2_sh) begin
          x_q                       <= x_q - ln2_sh;
          k_q[cmd_i.step[SHW-1:0]] <= 1'b1;
        end
      end
      snf_pkg::OP_SINIT: begin
        term_q <= r_val;
        sum_q  <= SER_ONE - $signed({2'b00, r_val});
      end
      snf_pkg::OP_MUL: begin
        dvd_q  <= term_prod[2*RW-1:RW];
        nrem_q <= '0;
      end
      snf_pkg::OP_DIV: begin
        dvd_q  <= dvd_next;
        nrem_q <= nrem_next;
      end
      snf_pkg::OP_ACCUM: begin
        term_q <= dvd_q;
        if (cmd_i.step[0]) sum_q <= sum_q - $signed({2'b00, dvd_q});
        else sum_q <= sum_q + $signed({2'b00, dvd_q});
      end
      snf_pkg::OP_RCP_D: d_q <= D_ONE + DW'(e_val);
      snf_pkg::OP_RCP_N: begin
        rr_q <= N_HIGH + DW'(d_q[DW-1:QW+1]);
        qn_q <= d_q[QW:1];
      end
      snf_pkg::OP_RCP: begin
        if (rcp_trial >= {1'b0, d_q}) begin
          rr_q <= DW'(rcp_trial - {1'b0, d_q});
          qn_q <= {qn_q[QW-2:0], 1'b1};
        end else begin
          rr_q <= rcp_trial[DW-1:0];
          qn_q <= {qn_q[QW-2:0], 1'b0};
        end
      end
      snf_pkg::OP_SIGN: s_q <= z_q[ZW-1] ? (P_ONE - p_val) : p_val;
      snf_pkg::OP_DER:  der_q <= der_prod[snf_pkg::DER_W+QW-2:QW-1];
      snf_pkg::OP_LOAD: begin
        out_sum_q <= z_q;
        out_sup_q <= act_sig_q;
        if (act_sig_q) begin
          out_act_q <= s_q[QW-1] ? '1 : s_q[QW-2:0];
          out_der_q <= der_q;
        end else begin
          out_act_q <= '0;
          out_der_q <= '0;
        end
      end
      default: ;
    endcase
  end

  assign weighted_sum_o = out_sum_q;
  assign activation_o   = out_act_q;
  assign derivative_o   = out_der_q;
  assign supported_o    = out_sup_q;

endmodule

@@ design/sigmoid_neuron_forward.sv @@
// top level of the sigmoid neuron forward block
// usage:
//   in_if carries one input/weight pair per word; last marks the final pair of
//   an evaluation. pairs are taken one per cycle while ready is high.
//   on the last word the bias is added, the sum is saturated to 32 bits and
//   the sigmoid and its derivative are evaluated by a range reduction loop,
//   a 12-term series loop, a reciprocal divider and a derivative multiplier.
//   out_if then holds one result word: weighted_sum, activation, derivative,
//   supported. the accumulator is cleared for the next evaluation.
//   when |z| >= 16.0 the reduction, series and reciprocal steps are skipped,
//   and when the activation is unsupported the sigmoid evaluation is skipped;
//   the series loop takes most of the evaluation time.
//   in_if ready stays low from the last word until the result is loaded.
//   the result register holds while out_if ready is low, and the next
//   evaluation streams in meanwhile; its result waits until the slot is free.
//   config writes (bias, activation select) go through cfg_we_i / cfg_idx_i /
//   cfg_wdata_i, to be made while the block is idle; it does not enforce this.
//   reset clears the accumulator, bias to zero, activation select to sigmoid.
`include "sigmoid_neuron_forward_macros.svh"

module sigmoid_neuron_forward (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [snf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [snf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  snf_in_if.sink                            in_if,
  snf_out_if.source                         out_if
);

  snf_pkg::dp_cmd_t     cmd;
  snf_pkg::dp_status_t  status;
  logic                 in_accept;

  assign in_accept = in_if.valid && in_if.ready;

  snf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_last_i   (in_if.last),
    .in_ready_o  (in_if.ready),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  snf_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_accept_i    (in_accept),
    .input_value_i  (in_if.input_value),
    .weight_value_i (in_if.weight_value),
    .cmd_i          (cmd),
    .status_o       (status),
    .weighted_sum_o (out_if.weighted_sum),
    .activation_o   (out_if.activation),
    .derivative_o   (out_if.derivative),
    .supported_o    (out_if.supported)
  );

  `SNF_ASSERT_NEXT(a_last_stops_input, clk_i, rst_ni, in_accept && in_if.last, !in_if.ready, "input taken right after last word")
  `SNF_ASSERT_NOW(a_unsupported_zero, clk_i, rst_ni, out_if.valid && !out_if.supported, (out_if.activation == '0) && (out_if.derivative == '0), "unsupported result not zero")
  `SNF_ASSERT_NOW(a_derivative_range, clk_i, rst_ni, out_if.valid, out_if.derivative <= snf_pkg::DER_MAX, "derivative above quarter scale")

endmodule

@@ tb/sv/sigmoid_neuron_forward_checker.sv @@
// result predictor and word checker for the sigmoid neuron forward block
`timescale 1ns / 100ps

module sigmoid_neuron_forward_checker
  import snf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  snf_in_if                     in_ch,
  snf_out_if                    out_ch,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam longint ACC_HI   = 64'sd549755813887;
  localparam longint ACC_LO   = -64'sd549755813888;
  localparam longint SUM_HI   = 64'sd2147483647;
  localparam longint SUM_LO   = -64'sd2147483648;
  localparam longint unsigned UNITY_Q32 = 64'd4294967296;
  localparam int TAYLOR_TERMS = 13;

  typedef struct {
    logic signed [SUM_W-1:0] weighted_sum;
    logic [ACT_W-1:0]        activation;
    logic [DER_W-1:0]        derivative;
    logic                    supported;
  } neuron_result_t;

  logic signed [SUM_W-1:0] bias_q;
  logic                    sigmoid_on;
  longint                  product_sum;
  neuron_result_t          pending_outputs[$];

  function automatic neuron_result_t evaluate_neuron(longint acc, logic signed [SUM_W-1:0] bias_val,
                                                     logic sig_en);
    neuron_result_t  res;
    longint          z;
    longint          mag;
    longint          series;
    longint unsigned x;
    longint unsigned k;
    longint unsigned r;
    longint unsigned term;
    longint unsigned e;
    longint unsigned d;
    longint unsigned p;
    longint unsigned s;
    z = acc + longint'(bias_val);
    if (z > SUM_HI) begin
      z = SUM_HI;
    end else if (z < SUM_LO) begin
      z = SUM_LO;
    end
    res.weighted_sum = SUM_W'(z);
    res.activation   = '0;
    res.derivative   = '0;
    res.supported    = sig_en;
    if (sig_en) begin
      mag = (z < 0) ? -z : z;
      if (mag >= longint'(MAG_LIMIT)) begin
        p = 64'd65536;
      end else begin
        // range reduction by ln2, then a short series for e^-r
        x = $unsigned(mag) << 8;
        k = x / LN2_Q32;
        r = x - k * LN2_Q32;
        term = UNITY_Q32;
        series = $signed(UNITY_Q32);
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
          term = ((term * r) >> 32) / longint'(n);
          if (n % 2 == 1) begin
            series = series - $signed(term);
          end else begin
            series = series + $signed(term);
          end
        end
        e = $unsigned(series) >> k;
        d = UNITY_Q32 + e;
        p = ((64'd1 << 48) + (d >> 1)) / d;
      end
      s = (z < 0) ? 64'd65536 - p : p;
      res.derivative = DER_W'((s * (64'd65536 - s) + 64'd32768) >> 16);
      res.activation = (s > 64'd65535) ? '1 : ACT_W'(s);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : observe
    neuron_result_t want;
    if (!rst_ni) begin
      bias_q       = '0;
      sigmoid_on   = 1'b1;
      product_sum  = 0;
      pending_outputs.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BIAS: begin
            bias_q = cfg_wdata_i;
          end
          CFG_ACT_SIGMOID: begin
            sigmoid_on = cfg_wdata_i[0];
          end
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        product_sum = product_sum + longint'(in_ch.input_value) * longint'(in_ch.weight_value);
        if (product_sum > ACC_HI) begin
          product_sum = ACC_HI;
        end else if (product_sum < ACC_LO) begin
          product_sum = ACC_LO;
        end
        if (in_ch.last) begin
          pending_outputs.insert(pending_outputs.size(),
                                 evaluate_neuron(product_sum, bias_q, sigmoid_on));
          product_sum = 0;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_outputs.size() == 0) begin
          $error("result word with no expectation pending");
          fail_count_o++;
        end else begin
          want = pending_outputs.pop_front();
          if (out_ch.weighted_sum !== want.weighted_sum) begin
            $error("weighted_sum: expected %0d, got %0d", want.weighted_sum, out_ch.weighted_sum);
            fail_count_o++;
          end
          if (out_ch.activation !== want.activation) begin
            $error("activation: expected %0d, got %0d", want.activation, out_ch.activation);
            fail_count_o++;
          end
          if (out_ch.derivative !== want.derivative) begin
            $error("derivative: expected %0d, got %0d", want.derivative, out_ch.derivative);
            fail_count_o++;
          end
          if (out_ch.supported !== want.supported) begin
            $error("supported: expected %0d, got %0d", want.supported, out_ch.supported);
            fail_count_o++;
          end
        end
      end
      pending_o = pending_outputs.size();
    end
  end

endmodule

@@ tb/sv/sigmoid_neuron_forward_test.sv @@
// stimulus and verdict for the sigmoid neuron forward block
`timescale 1ns / 100ps

module sigmoid_neuron_forward_test;
  import snf_pkg::*;

  localparam int SETTLE_CYCLES = 200;
  localparam int RAND_PHASES   = 10;
  localparam int PHASE_ITEMS   = 100;

  typedef enum {SPAN_FULL, SPAN_UNIT, SPAN_WIDE} span_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  int                    fail_count;
  int                    pending;
  bit                    source_calm = 1'b0;
  bit                    sink_calm = 1'b0;

  snf_in_if  in_ch();
  snf_out_if out_ch();

  sigmoid_neuron_forward u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  sigmoid_neuron_forward_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic signed [DATA_W-1:0] draw_value(span_e span);
    case (span)
      SPAN_FULL: return DATA_W'($urandom);
      SPAN_WIDE: return DATA_W'($urandom_range(0, 16383)) - 16'd8192;
      default:   return DATA_W'($urandom_range(0, 4095)) - 16'd2048;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_pair(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] w, logic fin);
    int gap;
    gap = source_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.input_value  <= a;
    in_ch.weight_value <= w;
    in_ch.last         <= fin;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_evaluation(int len, span_e span);
    for (int i = 0; i < len; i++) begin
      send_pair(draw_value(span), draw_value(span), i == len - 1);
    end
  endtask

  task automatic write_regs(logic [CFG_DATA_W-1:0] bias, logic sig_en);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_BIAS;
    cfg_wdata_i <= bias;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_ACT_SIGMOID;
    cfg_wdata_i <= {{(CFG_DATA_W-1){1'b0}}, sig_en};
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // wait for every result word, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] bias;
    int                    sent;
    int                    len;
    span_e                 span;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_BIAS;
    cfg_wdata_i        <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.input_value  <= '0;
    in_ch.weight_value <= '0;
    in_ch.last         <= 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: zero bias, sigmoid
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd32767, 16'sd32767, 1'b1);
    send_pair(-16'sd32768, 16'sd32767, 1'b1);
    send_pair(-16'sd32768, -16'sd32768, 1'b1);
    send_pair(16'sd4096, 16'sd4096, 1'b1);
    send_pair(-16'sd4096, 16'sd4096, 1'b1);
    // magnitude exactly at and just below the saturation threshold
    send_pair(16'sd16384, 16'sd16384, 1'b1);
    send_pair(16'sd16384, 16'sd16383, 1'b1);
    send_pair(-16'sd16384, 16'sd16383, 1'b1);
    send_pair(16'sd4096, 16'sd8192, 1'b0);
    send_pair(-16'sd4096, 16'sd2048, 1'b0);
    send_pair(16'sd1, 16'sd1, 1'b1);
    drain();

    // sum saturation at both ends
    write_regs(32'h7fff_ffff, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd32767, 16'sd32767, 1'b1);
    drain();
    write_regs(32'h8000_0000, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(-16'sd32768, 16'sd32767, 1'b1);
    drain();

    // unsupported activation
    write_regs(32'h0100_0000, 1'b0);
    send_pair(16'sd4096, 16'sd4096, 1'b1);
    send_pair(-16'sd32768, -16'sd32768, 1'b1);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       bias = 32'h7fff_ffff;
        1:       bias = 32'h8000_0000;
        2:       bias = '0;
        3:       bias = $urandom;
        default: bias = 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
      endcase
      source_calm = ($urandom_range(0, 3) == 0);
      sink_calm   = ($urandom_range(0, 3) == 0);
      write_regs(bias, ph % 4 != 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len  = ($urandom_range(0, 39) == 0) ? $urandom_range(64, 256) : $urandom_range(1, 8);
        span = span_e'($urandom_range(0, 2));
        send_evaluation(len, span);
        sent += len;
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
